// ===== rtl/fmod_pkg.sv =====
// ----------------------------------------------------------------------------
// fmod_pkg
// shared constants and controller/datapath command and status types
// ----------------------------------------------------------------------------
package fmod_pkg;

  localparam int WordW = 32;
  localparam int SigW  = 24;
  localparam int FracW = 23;
  localparam int ExpW  = 9;   // signed internal exponent width plus margin

  localparam logic [31:0] InfBits    = 32'h7F80_0000;
  localparam logic [31:0] QuietBit   = 32'h0040_0000;
  localparam logic [31:0] DefaultNan = 32'hFFC0_0000;

  typedef struct packed {
    logic load;      // capture operands and classify
    logic norm_x;    // shift x significand left one step
    logic norm_y;    // shift y significand left one step
    logic seed;      // start remainder from normalized operands
    logic rem_step;  // one restoring remainder step
    logic pack_step; // shift remainder left one step
    logic finish;    // form result word
  } fmod_cmd_t;

  typedef struct packed {
    logic special;   // result settled by classification
    logic x_normed;
    logic y_normed;
    logic rem_done;  // no shift left
    logic pack_done; // remainder zero, normalized or at subnormal limit
  } fmod_sts_t;

endpackage

// ===== rtl/fmod_datapath.sv =====
// ----------------------------------------------------------------------------
// fmod_datapath
// operand split, bit-serial remainder, normalize and pack
// ----------------------------------------------------------------------------
module fmod_datapath (
  input  logic                     clk,
  input  logic [31:0]              dividend_bits,
  input  logic [31:0]              divisor_bits,
  input  fmod_pkg::fmod_cmd_t      cmd,
  output fmod_pkg::fmod_sts_t      sts,
  output logic [31:0]              remainder_bits,
  output logic                     invalid_flag,
  output logic                     underflow_flag
);
  import fmod_pkg::*;

  localparam logic signed [ExpW:0] ExpOne = 1;

  logic [31:0]     x;
  logic [SigW-1:0] mx, my;
  logic [SigW:0]   rem;
  logic signed [ExpW:0] ex, ey, shift;
  logic            special;
  logic [31:0]     spec_res;
  logic            spec_inv;

  logic [30:0] ax, ay;
  logic [SigW:0] trial;
  logic signed [ExpW:0] k;
  logic [4:0]      rsh;
  logic [SigW-1:0] sub_sig;

  assign ax = dividend_bits[30:0];
  assign ay = divisor_bits[30:0];
  assign trial = {rem[SigW-1:0], 1'b0} - {1'b0, my};
  // divisor exponent at or below zero: result is the remainder shifted right
  assign rsh = 5'(ExpOne - ey);
  assign sub_sig = rem[SigW-1:0] >> rsh;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x <= dividend_bits;
      spec_inv <= 1'b0;
      special <= 1'b1;
      if ({1'b0, ax} > InfBits) begin
        spec_res <= dividend_bits | QuietBit;
      end else if ({1'b0, ay} > InfBits) begin
        spec_res <= divisor_bits | QuietBit;
      end else if ({1'b0, ax} == InfBits || ay == 31'd0) begin
        spec_res <= DefaultNan;
        spec_inv <= 1'b1;
      end else if (ax < ay) begin
        spec_res <= dividend_bits;
      end else begin
        special <= 1'b0;
        spec_res <= dividend_bits;
      end
      // subnormals start with exponent 1 and shift up one step at a time
      mx <= {(ax[30:23] != 8'd0), ax[22:0]};
      my <= {(ay[30:23] != 8'd0), ay[22:0]};
      ex <= (ax[30:23] == 8'd0) ? (ExpW+1)'(1) : (ExpW+1)'({2'b00, ax[30:23]});
      ey <= (ay[30:23] == 8'd0) ? (ExpW+1)'(1) : (ExpW+1)'({2'b00, ay[30:23]});
      k <= '0;
    end
    if (cmd.norm_x) begin
      mx <= {mx[SigW-2:0], 1'b0};
      ex <= ex - ExpOne;
    end
    if (cmd.norm_y) begin
      my <= {my[SigW-2:0], 1'b0};
      ey <= ey - ExpOne;
    end
    if (cmd.seed) begin
      // mx < 2*my so one subtract reduces it
      rem   <= ({1'b0, mx} >= {1'b0, my}) ? {1'b0, mx} - {1'b0, my} : {1'b0, mx};
      shift <= ex - ey;
    end
    if (cmd.rem_step) begin
      rem   <= trial[SigW] ? {rem[SigW-1:0], 1'b0} : trial;
      shift <= shift - ExpOne;
    end
    if (cmd.pack_step) begin
      rem <= {rem[SigW-1:0], 1'b0};
      k   <= k + ExpOne;
    end
    if (cmd.finish) begin
      invalid_flag   <= special & spec_inv;
      underflow_flag <= 1'b0;
      if (special) begin
        remainder_bits <= spec_res;
      end else if (rem == '0) begin
        remainder_bits <= {x[31], 31'd0};
      end else if (ey < ExpOne) begin
        remainder_bits <= {x[31], 8'd0, sub_sig[FracW-1:0]};
        underflow_flag <= 1'b1;
      end else if (rem[SigW-1]) begin
        remainder_bits <= {x[31], 8'(ey - k), rem[FracW-1:0]};
      end else begin
        // stopped at k = ey - 1: value is rem << (ey-1) as subnormal
        remainder_bits <= {x[31], 8'd0, rem[FracW-1:0]};
        underflow_flag <= 1'b1;
      end
    end
  end

  assign sts.special   = special;
  assign sts.x_normed  = mx[SigW-1];
  assign sts.y_normed  = my[SigW-1];
  assign sts.rem_done  = (shift == '0);
  assign sts.pack_done = (rem == '0) || rem[SigW-1] || (k == ey - ExpOne) || (ey < ExpOne);

endmodule

// ===== rtl/fmod_ctrl.sv =====
// ----------------------------------------------------------------------------
// fmod_ctrl
// sequencer for load, normalize, remainder loop, pack and output hold
// ----------------------------------------------------------------------------
module fmod_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_fire,
  input  logic                out_fire,
  input  fmod_pkg::fmod_sts_t sts,
  output fmod_pkg::fmod_cmd_t cmd,
  output logic                busy,
  output logic                out_valid
);
  import fmod_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_CLASS, S_NORM, S_SEED, S_REM, S_PACK, S_DONE, S_OUT
  } state_t;

  state_t state;

  always_comb begin
    cmd = '0;
    cmd.load = in_fire;
    case (state)
      S_NORM: begin
        cmd.norm_x = !sts.x_normed;
        cmd.norm_y = !sts.y_normed;
      end
      S_SEED: cmd.seed      = 1'b1;
      S_REM:  cmd.rem_step  = !sts.rem_done;
      S_PACK: cmd.pack_step = !sts.pack_done;
      // result register only written once the previous item has left it
      S_DONE: cmd.finish    = !out_valid || out_fire;
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!out_valid || out_fire)) begin
        out_valid <= 1'b1;
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE:  if (in_fire) state <= S_CLASS;
        S_CLASS: state <= sts.special ? S_DONE : S_NORM;
        S_NORM:  if (sts.x_normed && sts.y_normed) state <= S_SEED;
        S_SEED:  state <= S_REM;
        S_REM:   if (sts.rem_done) state <= S_PACK;
        S_PACK:  if (sts.pack_done) state <= S_DONE;
        S_DONE: begin
          if (!out_valid || out_fire) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/float32_remainder_fmod.sv =====
// ----------------------------------------------------------------------------
// float32_remainder_fmod
// single-precision fmod, exact, sign of x
// ----------------------------------------------------------------------------
// One item at a time. Special operands go straight from classification to the
// result; ordinary ones pass through classification, normalize steps (up to 23,
// both operands shift in parallel), seeding, the remainder loop over the exponent
// difference (up to 276, one restoring remainder bit per cycle) and renormalize
// steps (up to 23). A finished item also waits while the previous result is still
// held for m_tready. The result sits in an output register; a new item is
// taken once the previous item has moved there.
module float32_remainder_fmod (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // dividend_bits[31:0], divisor_bits[63:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // remainder_bits, invalid_flag, underflow_flag, zero pad
);
  import fmod_pkg::*;

  fmod_cmd_t cmd;
  fmod_sts_t sts;
  logic busy, in_fire, out_fire;
  logic [31:0] res;
  logic inv, unf, dp_unused;

  assign s_tready = !busy;
  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;
  assign dp_unused = 1'b0;
  assign m_tdata  = {5'd0, dp_unused, unf, inv, res};

  fmod_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_fire(out_fire),
    .sts(sts), .cmd(cmd), .busy(busy), .out_valid(m_tvalid)
  );

  fmod_datapath u_dp (
    .clk(clk), .dividend_bits(s_tdata[31:0]), .divisor_bits(s_tdata[63:32]),
    .cmd(cmd), .sts(sts), .remainder_bits(res), .invalid_flag(inv),
    .underflow_flag(unf)
  );

endmodule

// ===== verif/fmod_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmod_checker
// watches both streams of the fmod block, computes the exact single-precision
// remainder of every accepted operand pair and compares it with each result
// ----------------------------------------------------------------------------
module fmod_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  output int          errors,
  output int          pending
);
  import fmod_pkg::*;

  typedef struct packed {
    logic [31:0] rem;
    logic        invalid;
    logic        underflow;
  } fmod_res_t;

  fmod_res_t remainders_due[$];

  // significand and biased exponent of a nonzero finite magnitude
  function automatic void unpack_mag(input logic [31:0] mag, output logic [31:0] sig,
                                     output int expo);
    int lz;
    lz = 0;
    if (mag < 32'h0080_0000) begin
      while (mag[31 - lz] == 1'b0) lz++;
      sig  = mag << (lz - 8);
      expo = 9 - lz;
    end else begin
      sig  = {8'h0, 1'b1, mag[22:0]};
      expo = int'(mag[30:23]);
    end
  endfunction

  function automatic fmod_res_t fmod_of(input logic [31:0] x, input logic [31:0] y);
    fmod_res_t   r;
    logic [31:0] ax, ay, mx, my, rem;
    int          ex, ey, sh, k;
    ax = x & 32'h7FFF_FFFF;
    ay = y & 32'h7FFF_FFFF;
    r  = '{rem: x, invalid: 1'b0, underflow: 1'b0};
    if (ax > InfBits) begin
      r.rem = x | QuietBit;
    end else if (ay > InfBits) begin
      r.rem = y | QuietBit;
    end else if (ax == InfBits || ay == 0) begin
      r.rem     = DefaultNan;
      r.invalid = 1'b1;
    end else if (ax >= ay) begin
      unpack_mag(ax, mx, ex);
      unpack_mag(ay, my, ey);
      // bit-serial long division keeps the exact remainder
      rem = mx % my;
      for (sh = ex - ey; sh > 0; sh--) begin
        rem = {rem[30:0], 1'b0};
        if (rem >= my) rem = rem - my;
      end
      if (rem != 0) begin
        k = 0;
        while (rem[23 - k] == 1'b0) k++;
        if (k < ey) begin
          rem = (32'(ey - k) << 23) | ((rem << k) & 32'h007F_FFFF);
        end else begin
          rem = (ey > 0) ? rem << (ey - 1) : rem >> (1 - ey);
          r.underflow = 1'b1;
        end
      end
      r.rem = rem | (x & 32'h8000_0000);
    end
    return r;
  endfunction

  assign pending = remainders_due.size();

  always @(posedge clk) begin
    fmod_res_t want, got;
    if (rst) begin
      errors <= 0;
    end else begin
      if (s_tvalid && s_tready) remainders_due.push_back(fmod_of(s_tdata[31:0], s_tdata[63:32]));
      if (m_tvalid && m_tready) begin
        got = '{rem: m_tdata[31:0], invalid: m_tdata[32], underflow: m_tdata[33]};
        if (remainders_due.size() == 0) begin
          $display("%t: unexpected result %h", $time, got.rem);
          errors <= errors + 1;
        end else begin
          want = remainders_due.pop_front();
          if (got.rem !== want.rem || got.invalid !== want.invalid ||
              got.underflow !== want.underflow) begin
            $display("%t: expected rem %h inv %b unf %b, got rem %h inv %b unf %b", $time,
                     want.rem, want.invalid, want.underflow,
                     got.rem, got.invalid, got.underflow);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// directed special operands then random float pairs through the fmod block
// ----------------------------------------------------------------------------
module testbench;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  int          errors, pending;
  int          sent = 0;
  bit          calm = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  float32_remainder_fmod i_dut (.*);
  fmod_checker u_check (.*);

  // random pattern biased toward interesting exponents
  function automatic logic [31:0] rand_float();
    logic [31:0] f;
    f = $urandom;
    case ($urandom_range(0, 9))
      0: f[30:23] = 8'h00;
      1: f[30:23] = 8'hFF;
      2: f = f & 32'h8000_0000;
      3: f[30:23] = 8'(127 + $urandom_range(0, 6) - 3);
      default: ;
    endcase
    return f;
  endfunction

  always @(posedge clk) m_tready <= calm || ($urandom_range(0, 99) >= 9);

  task automatic send_pair(input logic [31:0] x, input logic [31:0] y);
    while (!calm && $urandom_range(0, 99) < 9) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {y, x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  initial begin
    logic [31:0] dx [12];
    logic [31:0] dy [12];
    int          guard;
    dx = '{32'h7FC0_0001, 32'h7F80_0001, 32'h3F80_0000, 32'h7F80_0000, 32'h4049_0FDB,
           32'h3F00_0000, 32'h7F7F_FFFF, 32'h0000_0003, 32'h8000_0000, 32'h4080_0000,
           32'h7F7F_FFFF, 32'hC0E0_0000};
    dy = '{32'h7F80_0000, 32'hFF80_0001, 32'h0000_0000, 32'h3F80_0000, 32'h3F80_0000,
           32'h3F80_0000, 32'h0000_0001, 32'h0000_0002, 32'h3F80_0000, 32'h4000_0000,
           32'h0080_0001, 32'h4040_0000};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    calm = 1'b1;
    foreach (dx[i]) send_pair(dx[i], dy[i]);
    send_pair(32'hFFFF_FFFF, 32'h0);
    send_pair(32'h0, 32'hFFFF_FFFF);
    calm = 1'b0;
    for (int n = 0; n < 1040; n++) begin
      calm = (n >= 400 && n < 550);
      send_pair(rand_float(), rand_float());
    end
    s_tvalid <= 1'b0;
    guard = 0;
    while (pending != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (400) @(posedge clk);
    $display("sent %0d operand pairs: nan, infinity, zero, subnormal and random cases", sent);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
